// File: hdl/assert_macros.svh
// Assertion macros used by the pixel word ALU port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the clock cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/pwa_pkg.sv
// Types, register indexes, opcodes and helpers for the pixel word ALU
`default_nettype none
package pwa_pkg;

    localparam int unsigned DIV_STAGES = 64;

    typedef enum logic [3:0] {
        OP_XOR     = 4'd0,
        OP_OR      = 4'd1,
        OP_AND     = 4'd2,
        OP_ADD     = 4'd3,
        OP_SUB     = 4'd4,
        OP_MUL     = 4'd5,
        OP_DIV     = 4'd6,
        OP_DIV64   = 4'd7,
        OP_BITREV  = 4'd8,
        OP_BYTEREV = 4'd9,
        OP_OPAQUE  = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_WORD  = 2'd1,
        SRC_FIELD = 2'd2
    } src_t;

    typedef enum logic [2:0] {
        REG_OPCODE   = 3'd0,
        REG_SOURCE   = 3'd1,
        REG_CONST    = 3'd2,
        REG_WORD     = 3'd3,
        REG_KEEP     = 3'd4
    } reg_index_t;

    localparam logic [7:0] ALPHA_ONES = 8'hFF;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic [31:0] operand_in;
        logic        last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        divide_by_zero;
        logic        last_out;
    } out_word_t;

    typedef struct packed {
        logic [3:0]  op;
        logic        keep;
        logic        last;
        logic [31:0] pix;
        logic [31:0] simple;
        logic        dz;
        logic        neg;
        logic        qzero;
        logic [31:0] rem;
        logic [63:0] dvd;
        logic [31:0] dsr;
        logic [31:0] quo;
    } div_stage_t;

    function automatic logic [31:0] bit_reverse(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    function automatic logic [31:0] byte_reverse(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// File: hdl/pixel_word_alu.sv
// Pixel word ALU: top level with configuration registers and the divide pipeline
// Every pixel word runs through one input register fed by the operand select,
// one setup stage (logic ops, add, subtract, multiply, reversals, opaque alpha,
// divider operands), 64 restoring divide stages of one quotient bit each and
// one output register. One word enters per cycle; the whole pipe holds while
// the output word is stalled, and in_stall follows out_stall only while the
// output register is full. Configuration must be written idle.
`default_nettype none
module pixel_word_alu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire pwa_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output pwa_pkg::out_word_t     out_word,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);

    logic [3:0]  opcode_reg;
    logic [1:0]  source_reg;
    logic [7:0]  const_reg;
    logic [31:0] word_reg;
    logic        keep_reg;

    logic advance;

    logic              s0_valid_reg;
    pwa_pkg::in_word_t s0_word_reg;
    logic [31:0]       s0_opnd_reg;
    logic [31:0]       opnd_next;

    logic [pwa_pkg::DIV_STAGES:0] dv_valid_reg;
    pwa_pkg::div_stage_t          dv_reg [0:pwa_pkg::DIV_STAGES];
    pwa_pkg::div_stage_t          setup_next;

    logic               out_valid_reg;
    pwa_pkg::out_word_t out_word_reg;
    pwa_pkg::out_word_t out_next;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= 4'd0;
            source_reg <= 2'd0;
            const_reg  <= 8'd0;
            word_reg   <= 32'd0;
            keep_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwa_pkg::REG_OPCODE: opcode_reg <= cfg_data[3:0];
                pwa_pkg::REG_SOURCE: source_reg <= cfg_data[1:0];
                pwa_pkg::REG_CONST:  const_reg  <= cfg_data[7:0];
                pwa_pkg::REG_WORD:   word_reg   <= cfg_data;
                pwa_pkg::REG_KEEP:   keep_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (source_reg)
            pwa_pkg::SRC_CONST: opnd_next = {4{const_reg}};
            pwa_pkg::SRC_WORD:  opnd_next = word_reg;
            default:            opnd_next = in_word.operand_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_word_reg <= in_word;
            s0_opnd_reg <= opnd_next;
        end
    end

    always_comb
    begin
        logic [31:0] p;
        logic [31:0] o;
        logic [31:0] abs_p;
        logic [31:0] abs_o;
        logic [31:0] prod;
        p     = s0_word_reg.pixel_in;
        o     = s0_opnd_reg;
        abs_p = p[31] ? (32'd0 - p) : p;
        abs_o = o[31] ? (32'd0 - o) : o;
        prod  = p * o;
        setup_next.op    = opcode_reg;
        setup_next.keep  = keep_reg;
        setup_next.last  = s0_word_reg.last_pixel;
        setup_next.pix   = p;
        setup_next.dz    = (o == 32'd0);
        setup_next.neg   = p[31] ^ o[31];
        setup_next.qzero = o[31];
        setup_next.rem   = 32'd0;
        setup_next.quo   = 32'd0;
        if (opcode_reg == pwa_pkg::OP_DIV)
        begin
            setup_next.dvd = {32'd0, abs_p};
            setup_next.dsr = abs_o;
        end
        else
        begin
            setup_next.dvd = {p, 32'd0};
            setup_next.dsr = o;
        end
        unique case (opcode_reg)
            pwa_pkg::OP_XOR:     setup_next.simple = p ^ o;
            pwa_pkg::OP_OR:      setup_next.simple = p | o;
            pwa_pkg::OP_AND:     setup_next.simple = p & o;
            pwa_pkg::OP_ADD:     setup_next.simple = p + o;
            pwa_pkg::OP_SUB:     setup_next.simple = p - o;
            pwa_pkg::OP_MUL:     setup_next.simple = prod;
            pwa_pkg::OP_BITREV:  setup_next.simple = pwa_pkg::bit_reverse(p);
            pwa_pkg::OP_BYTEREV: setup_next.simple = pwa_pkg::byte_reverse(p);
            pwa_pkg::OP_OPAQUE:  setup_next.simple = {pwa_pkg::ALPHA_ONES, p[23:0]};
            default:             setup_next.simple = p;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else if (advance)
        begin
            dv_valid_reg <= {dv_valid_reg[pwa_pkg::DIV_STAGES-1:0], s0_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_reg[0] <= setup_next;
        end
    end

    for (genvar i = 0; i < pwa_pkg::DIV_STAGES; i++)
    begin : g_div
        pwa_pkg::div_stage_t step_next;
        always_comb
        begin
            logic [32:0] t;
            logic        ge;
            t  = {dv_reg[i].rem, dv_reg[i].dvd[63]};
            ge = (t >= {1'b0, dv_reg[i].dsr});
            step_next     = dv_reg[i];
            step_next.rem = ge ? 32'(t - {1'b0, dv_reg[i].dsr}) : t[31:0];
            step_next.dvd = {dv_reg[i].dvd[62:0], 1'b0};
            step_next.quo = {dv_reg[i].quo[30:0], ge};
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_reg[i+1] <= step_next;
            end
        end
    end

    always_comb
    begin
        pwa_pkg::div_stage_t d;
        logic [31:0] res;
        logic        dz;
        d  = dv_reg[pwa_pkg::DIV_STAGES];
        dz = 1'b0;
        unique case (d.op)
            pwa_pkg::OP_DIV:
            begin
                dz  = d.dz;
                res = d.dz ? 32'hFFFF_FFFF : (d.neg ? (32'd0 - d.quo) : d.quo);
            end
            pwa_pkg::OP_DIV64:
            begin
                dz  = d.dz;
                res = d.dz ? 32'hFFFF_FFFF : (d.qzero ? 32'd0 : d.quo);
            end
            default: res = d.simple;
        endcase
        if (d.keep && d.op != pwa_pkg::OP_OPAQUE)
        begin
            res = {d.pix[31:24], res[23:0]};
        end
        out_next.pixel_out      = res;
        out_next.divide_by_zero = dz;
        out_next.last_out       = d.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid_reg[pwa_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/pwa_checker.sv
// Port checker for the pixel word ALU and its bind
`default_nettype none
`include "assert_macros.svh"
module pwa_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire pwa_pkg::out_word_t out_word
);

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")
    `CHK_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output stall")
    `CHK_IMPL(a_no_stall, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
    `CHK_IMPL(a_dz_ones, clk, rst_n, out_valid && out_word.divide_by_zero, out_word.pixel_out[23:0] == 24'hFFFFFF, "divide by zero word not all ones")

endmodule

bind pixel_word_alu pwa_checker u_pwa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
`default_nettype wire

// File: sim/pwa_checker.sv
// Checker for the pixel word ALU: predicts each output word and compares it
module pwa_scoreboard (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire pwa_pkg::in_word_t in_word,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire pwa_pkg::out_word_t out_word,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [3:0]         cur_op;
    logic [1:0]         cur_src;
    logic [7:0]         cur_const;
    logic [31:0]        cur_word;
    logic               cur_keep;
    pwa_pkg::out_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic pwa_pkg::out_word_t predict_pixel(pwa_pkg::in_word_t w);
        pwa_pkg::out_word_t r;
        logic [31:0] opnd;
        logic [31:0] res;
        logic [63:0] num;
        logic [63:0] den;
        logic        restore;
        r = '0;
        restore = cur_keep;
        case (cur_src)
            pwa_pkg::SRC_CONST: opnd = {4{cur_const}};
            pwa_pkg::SRC_WORD:  opnd = cur_word;
            default:            opnd = w.operand_in;
        endcase
        case (cur_op)
            pwa_pkg::OP_XOR:  res = w.pixel_in ^ opnd;
            pwa_pkg::OP_OR:   res = w.pixel_in | opnd;
            pwa_pkg::OP_AND:  res = w.pixel_in & opnd;
            pwa_pkg::OP_ADD:  res = w.pixel_in + opnd;
            pwa_pkg::OP_SUB:  res = w.pixel_in - opnd;
            pwa_pkg::OP_MUL:  res = w.pixel_in * opnd;
            pwa_pkg::OP_DIV, pwa_pkg::OP_DIV64:
            begin
                if (opnd == 0)
                begin
                    res = '1;
                    r.divide_by_zero = 1'b1;
                end
                else if (cur_op == pwa_pkg::OP_DIV)
                    res = 32'($signed(64'($signed(w.pixel_in))) / $signed(64'($signed(opnd))));
                else
                begin
                    num = {w.pixel_in, 32'h0};
                    den = 64'($signed(opnd));
                    res = 32'(num / den);
                end
            end
            pwa_pkg::OP_BITREV:
                for (int i = 0; i < 32; i++)
                    res[i] = w.pixel_in[31 - i];
            pwa_pkg::OP_BYTEREV: res = {w.pixel_in[7:0], w.pixel_in[15:8], w.pixel_in[23:16],
                                        w.pixel_in[31:24]};
            pwa_pkg::OP_OPAQUE:
            begin
                res = {8'hFF, w.pixel_in[23:0]};
                restore = 1'b0;
            end
            default: res = w.pixel_in;
        endcase
        if (restore)
            res[31:24] = w.pixel_in[31:24];
        r.pixel_out = res;
        r.last_out = w.last_pixel;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pwa_pkg::out_word_t e;
        if (!rst_n)
        begin
            cur_op = pwa_pkg::OP_XOR;
            cur_src = pwa_pkg::SRC_CONST;
            cur_const = '0;
            cur_word = '0;
            cur_keep = 1'b1;
            errors = 0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", out_word.pixel_out, '0);
                else
                begin
                    e = expected_words.pop_front();
                    if (out_word.pixel_out !== e.pixel_out)
                        report_mismatch("pixel_out", out_word.pixel_out, e.pixel_out);
                    if (out_word.divide_by_zero !== e.divide_by_zero)
                        report_mismatch("divide_by_zero", 32'(out_word.divide_by_zero),
                                        32'(e.divide_by_zero));
                    if (out_word.last_out !== e.last_out)
                        report_mismatch("last_out", 32'(out_word.last_out), 32'(e.last_out));
                end
            end
            if (in_valid && !in_stall)
                expected_words.push_back(predict_pixel(in_word));
            if (cfg_we)
                case (cfg_index)
                    pwa_pkg::REG_OPCODE: cur_op = cfg_data[3:0];
                    pwa_pkg::REG_SOURCE: cur_src = cfg_data[1:0];
                    pwa_pkg::REG_CONST:  cur_const = cfg_data[7:0];
                    pwa_pkg::REG_WORD:   cur_word = cfg_data;
                    pwa_pkg::REG_KEEP:   cur_keep = cfg_data[0];
                    default: ;
                endcase
        end
    end
endmodule

// File: sim/tb.sv
// Testbench top for the pixel word ALU: stimulus, register phases and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pwa_pkg::in_word_t  in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pwa_pkg::out_word_t out_word;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 errors;
    int                 pending;
    int                 cycles = 0;
    bit                 hold_off = 1'b0;

    localparam int LIMIT = 2000000;

    always #5 clk = ~clk;

    pixel_word_alu DUT (.*);

    pwa_scoreboard checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            case ($urandom_range(0, 3))
                0: out_stall <= ($urandom_range(0, 2) == 0);
                1: out_stall <= ($urandom_range(0, 9) == 0);
                default: out_stall <= 1'b0;
            endcase
    end

    task automatic write_reg(pwa_pkg::reg_index_t idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_pixel(logic [31:0] pix, logic [31:0] opnd, logic last);
        in_valid <= 1'b1;
        in_word <= '{pixel_in: pix, operand_in: opnd, last_pixel: last};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic random_pixels(int count, bit gaps);
        logic [31:0] pix;
        logic [31:0] opnd;
        int burst;
        for (int i = 0; i < count; i++)
        begin
            pix = $urandom();
            opnd = $urandom();
            case ($urandom_range(0, 7))
                0: opnd = 0;
                1: opnd = '1;
                2: opnd = $urandom_range(1, 16);
                3: pix = 32'h8000_0000;
                default: ;
            endcase
            send_pixel(pix, opnd, $urandom_range(0, 15) == 0);
            if (gaps && burst-- <= 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst = $urandom_range(0, 20);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] corner[8];
        corner = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                   32'h1234_5678, 32'hFF00_00FF, 32'h00FF_FF00};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'h0, 1'b1);
        in_valid <= 1'b0;
        drain_pipe();
        write_reg(pwa_pkg::REG_SOURCE, 32'(pwa_pkg::SRC_FIELD));
        write_reg(pwa_pkg::REG_KEEP, 32'h0);
        for (int op = 0; op <= 15; op++)
        begin
            write_reg(pwa_pkg::REG_OPCODE, op);
            send_pixel(corner[op % 8], corner[(op + 3) % 8], op[0]);
            send_pixel(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
            send_pixel(32'hDEAD_BEEF, 32'h0, 1'b1);
            in_valid <= 1'b0;
            drain_pipe();
        end

        for (int phase = 0; phase < 22; phase++)
        begin
            write_reg(pwa_pkg::REG_OPCODE, phase < 16 ? phase : $urandom_range(0, 15));
            write_reg(pwa_pkg::REG_SOURCE, $urandom_range(0, 3));
            write_reg(pwa_pkg::REG_CONST,
                      phase == 1 ? 32'hFF : phase == 2 ? 0 : $urandom_range(0, 255));
            write_reg(pwa_pkg::REG_WORD, phase == 3 ? 0 : phase == 4 ? '1 : $urandom());
            write_reg(pwa_pkg::REG_KEEP, $urandom_range(0, 1));
            if (phase == 5)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    random_pixels(70, 1'b0);
                join
            end
            else
                random_pixels(70, phase % 3 != 0);
            drain_pipe();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: pixel_word_alu.f
+incdir+hdl
hdl/pwa_pkg.sv
hdl/pixel_word_alu.sv
hdl/pwa_checker.sv
sim/pwa_checker.sv
sim/tb.sv
